### hw/rtl/smvf_pkg.sv
// ----------------------------------------------------------------------------
// smvf_pkg
// Shared widths, limits and codes of the slab mean void fill core.
// ----------------------------------------------------------------------------
package smvf_pkg;

  localparam int DENS_W  = 32;
  localparam int RAY_W   = 24;
  localparam int THR_W   = 16;
  localparam int SUM_W   = 52;
  localparam int CNT_W   = 21;
  localparam int MAX_SLAB_CELLS = 1048576;

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

  // Command on the input tuser
  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_RESOLVE    = 1'b1;

  // Result kind on the output tuser
  typedef enum logic [1:0] {
    FILL_KEPT = 2'd0,
    FILL_MEAN = 2'd1,
    FILL_ZERO = 2'd2
  } fill_kind_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/smvf_div.sv
// ----------------------------------------------------------------------------
// smvf_div
// Restoring divider: slab sum over cell count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smvf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [smvf_pkg::SUM_W-1:0]    dividend,
  input  logic [smvf_pkg::CNT_W-1:0]    divisor,
  output smvf_pkg::div_stat_t           stat,
  output logic [smvf_pkg::DENS_W-1:0]   quotient
);

  localparam logic [smvf_pkg::DIV_STEP_W-1:0] LAST_STEP =
    smvf_pkg::DIV_STEP_W'(smvf_pkg::DIV_STEPS - 1);

  logic                              busy_r;
  logic                              done_r;
  logic [smvf_pkg::DIV_STEP_W-1:0]   step_r;
  logic [smvf_pkg::SUM_W-1:0]        dvd_r;
  logic [smvf_pkg::CNT_W-1:0]        dsr_r;
  logic [smvf_pkg::CNT_W-1:0]        rem_r;

  logic [smvf_pkg::CNT_W:0]          shifted;
  logic [smvf_pkg::CNT_W+1:0]        trial;
  logic                              borrow;

  // Shift in the next dividend bit and try one subtraction
  assign shifted = {rem_r, dvd_r[smvf_pkg::SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};
  assign borrow  = trial[smvf_pkg::CNT_W+1];

  // Quotient bits fill the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[smvf_pkg::SUM_W-2:0], ~borrow};
      rem_r <= borrow ? shifted[smvf_pkg::CNT_W-1:0] : trial[smvf_pkg::CNT_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r[smvf_pkg::DENS_W-1:0];

endmodule

### hw/rtl/slab_mean_void_fill_core.sv
// ----------------------------------------------------------------------------
// slab_mean_void_fill_core
// Per-slab mean of positive densities and void filling of resolve cells.
// ----------------------------------------------------------------------------
// Accumulate words (tuser 0) and resolve words (tuser 1) are taken from the
// input; a resolve word puts one result word in the output register, and the
// next input word is taken while that result waits as long as the result is
// taken in the same cycle. An accumulate word with tlast set on a slab that
// holds at least one positive cell starts the restoring divider, which
// produces one quotient bit per cycle: the input stays not ready through the
// 52 divide steps and until the mean is latched. A slab with no positive cell
// latches a mean of 0 without a stall. Up to 1048576 positive cells count
// toward a slab; further ones are dropped until the next tlast.
// ray_threshold sits at byte address 0 of the APB port.
module slab_mean_void_fill_core (
  input  logic         clk,
  input  logic         rst_n,
  // tdata: density[31:0], hit_count[55:32], theoretical_count[79:56],
  //        before_count[103:80]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic         in_tlast,   // last_of_slab
  input  logic         in_tuser,   // command
  // tdata: out_density[31:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  output logic [1:0]   out_tuser,  // fill_kind[1:0]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  localparam logic [smvf_pkg::CNT_W-1:0] CNT_CAP = smvf_pkg::CNT_W'(smvf_pkg::MAX_SLAB_CELLS);

  state_t                          state_r;
  logic [smvf_pkg::THR_W-1:0]      thr_r;
  logic [smvf_pkg::SUM_W-1:0]      sum_r;
  logic [smvf_pkg::CNT_W-1:0]      cnt_r;
  logic [smvf_pkg::DENS_W-1:0]     mean_r;
  logic                            out_valid_r;
  logic [smvf_pkg::DENS_W-1:0]     out_dens_r;
  smvf_pkg::fill_kind_t            out_kind_r;

  logic [smvf_pkg::DENS_W-1:0]     dens;
  logic [smvf_pkg::RAY_W-1:0]      hits;
  logic [smvf_pkg::RAY_W-1:0]      theo;
  logic [smvf_pkg::RAY_W-1:0]      before_cnt;
  logic                            in_acc;
  logic                            take_cell;
  logic [smvf_pkg::SUM_W-1:0]      sum_nxt;
  logic [smvf_pkg::CNT_W-1:0]      cnt_nxt;
  logic [smvf_pkg::RAY_W:0]        rays;
  logic                            rays_ok;
  logic                            div_start;
  smvf_pkg::div_stat_t             div_stat;
  logic [smvf_pkg::DENS_W-1:0]     div_q;
  logic                            cfg_wr;

  assign dens       = in_tdata[31:0];
  assign hits       = in_tdata[55:32];
  assign theo       = in_tdata[79:56];
  assign before_cnt = in_tdata[103:80];

  // Take a word when idle and the output slot is free or draining
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Add a positive density while the slab count has room
  assign take_cell = !dens[smvf_pkg::DENS_W-1] && (dens != '0) && (cnt_r < CNT_CAP);
  assign sum_nxt   = take_cell ? sum_r + smvf_pkg::SUM_W'(dens) : sum_r;
  assign cnt_nxt   = take_cell ? cnt_r + 1'b1 : cnt_r;

  // Divide only when the closing slab has a positive cell
  assign div_start = in_acc && (in_tuser == smvf_pkg::CMD_ACCUMULATE) && in_tlast &&
                     (cnt_nxt != '0);

  // Effective rays; a borrow means a negative count, which always passes
  assign rays    = {1'b0, theo} - {1'b0, before_cnt};
  assign rays_ok = rays[smvf_pkg::RAY_W] ||
                   (rays[smvf_pkg::RAY_W-1:0] <= smvf_pkg::RAY_W'(thr_r));

  smvf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (cnt_nxt),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Sequencer, accumulators and latched mean
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      mean_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == smvf_pkg::CMD_ACCUMULATE)) begin
            if (in_tlast) begin
              sum_r <= '0;
              cnt_r <= '0;
              if (cnt_nxt == '0) begin
                mean_r <= '0;
              end else begin
                state_r <= ST_DIV;
              end
            end else begin
              sum_r <= sum_nxt;
              cnt_r <= cnt_nxt;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            mean_r  <= div_q;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register: load on a resolve word, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (in_tuser == smvf_pkg::CMD_RESOLVE)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == smvf_pkg::CMD_RESOLVE)) begin
      if (!dens[smvf_pkg::DENS_W-1]) begin
        out_dens_r <= dens;
        out_kind_r <= smvf_pkg::FILL_KEPT;
      end else if ((hits != '0) && rays_ok) begin
        out_dens_r <= mean_r;
        out_kind_r <= smvf_pkg::FILL_MEAN;
      end else begin
        out_dens_r <= '0;
        out_kind_r <= smvf_pkg::FILL_ZERO;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_dens_r;
  assign out_tuser  = out_kind_r;

  // Configuration register
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= smvf_pkg::THR_RESET;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      thr_r <= cfg_pwdata[smvf_pkg::THR_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, thr_r};
  assign cfg_pready = 1'b1;

  // Checks
  a_no_take_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !in_tready)
    else $error("input taken while divider runs");

  a_div_enters_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == ST_DIV) && div_stat.busy)
    else $error("divider start without divide state");

  a_resolve_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == smvf_pkg::CMD_RESOLVE)) |=> out_valid_r)
    else $error("resolve word gave no result");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("slab cell count above cap");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider done outside divide state");

endmodule

### dv/tb_slab_mean_void_fill_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slab_mean_void_fill_core
// Streams accumulate and resolve words through the slab mean void fill core
// under bursty input and stalling output, tracks the slab mean in a bench
// model and compares every resolved density and fill kind in order. Covers
// several ray thresholds, empty slabs and extreme field values.
// ----------------------------------------------------------------------------
module tb_slab_mean_void_fill_core;
  import smvf_pkg::*;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int DRAIN_CYCLES = 64;    // divide pass plus latch, with margin
  localparam int FEED_DEPTH   = 32;
  localparam int HOLD_LEN     = 240;
  localparam logic [2:0] ADDR_RAY_THRESHOLD = 3'd0;

  typedef struct packed {
    logic             cmd;
    logic [DENS_W-1:0] density;      // signed Q16.16
    logic [RAY_W-1:0] hits;
    logic [RAY_W-1:0] theo_cnt;
    logic [RAY_W-1:0] before_cnt;
    logic             last;
  } voxel_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    fill_kind_t        kind;
  } fill_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;    // density, hit_count, theoretical_count, before_count
  logic         in_tlast = 1'b0;  // last_of_slab
  logic         in_tuser = 1'b0;  // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;        // out_density
  logic [1:0]   out_tuser;        // fill_kind
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Slab model state
  logic [SUM_W-1:0]  pos_sum = '0;
  logic [CNT_W-1:0]  pos_count = '0;
  logic [DENS_W-1:0] slab_mean = '0;
  logic [THR_W-1:0]  ray_thr = THR_RESET;

  voxel_t voxel_feed[$];
  fill_t  pending_fills[$];

  int cells_queued = 0;
  int cells_taken = 0;
  int words_out = 0;
  int word_errors = 0;
  int cfg_errors = 0;
  int n_accum = 0, n_resolve = 0, n_latch = 0;
  int n_kept = 0, n_mean = 0, n_zero = 0, n_thr = 1;
  int cycles = 0;

  logic   in_fire = 1'b0;
  int     gap_left = 0, burst_left = 0;
  voxel_t drv_voxel;
  voxel_t mon_voxel;
  fill_t  mon_fill;
  logic [31:0] rx_cycle = '0;
  int     hold_left = 0, holds_done = 0;

  slab_mean_void_fill_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the slab model by one accepted word; queue the fill it yields
  task automatic track_slab(input voxel_t v);
    logic [SUM_W-1:0] quot;
    logic signed [RAY_W+1:0] rays;
    fill_t f;
    if (v.cmd == CMD_ACCUMULATE) begin
      n_accum++;
      if (!v.density[DENS_W-1] && v.density != '0 &&
          pos_count < CNT_W'(MAX_SLAB_CELLS)) begin
        pos_sum = pos_sum + {{(SUM_W-DENS_W){1'b0}}, v.density};
        pos_count = pos_count + 1'b1;
      end
      if (v.last) begin
        n_latch++;
        quot = (pos_count != '0) ? pos_sum / {{(SUM_W-CNT_W){1'b0}}, pos_count} : '0;
        slab_mean = quot[DENS_W-1:0];
        pos_sum = '0;
        pos_count = '0;
      end
    end else begin
      n_resolve++;
      rays = $signed({2'b00, v.theo_cnt}) - $signed({2'b00, v.before_cnt});
      if (!v.density[DENS_W-1]) begin
        f.density = v.density;
        f.kind = FILL_KEPT;
      end else if (v.hits != '0 &&
                   rays <= $signed({{(RAY_W+2-THR_W){1'b0}}, ray_thr})) begin
        f.density = slab_mean;
        f.kind = FILL_MEAN;
      end else begin
        f.density = '0;
        f.kind = FILL_ZERO;
      end
      pending_fills.push_back(f);
    end
  endtask

  function automatic voxel_t mk_voxel(input logic cmd, input logic [31:0] dens,
                                      input logic [23:0] hits, input logic [23:0] theo,
                                      input logic [23:0] bef, input logic last);
    voxel_t v;
    v.cmd = cmd;
    v.density = dens;
    v.hits = hits;
    v.theo_cnt = theo;
    v.before_cnt = bef;
    v.last = last;
    return v;
  endfunction

  function automatic voxel_t rand_accum(input logic last);
    voxel_t v;
    v.cmd = CMD_ACCUMULATE;
    v.last = last;
    v.hits = 24'($urandom);
    v.theo_cnt = 24'($urandom);
    v.before_cnt = 24'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: v.density = $urandom_range(1, 32'h0010_0000);
      3, 4, 5: v.density = $urandom_range(1, 32'h7FFF_FFFF);
      6:       v.density = '0;
      7, 8:    v.density = $urandom | 32'h8000_0000;
      default: v.density = 32'h7FFF_FFFF;
    endcase
    return v;
  endfunction

  // Aim the effective ray count around the current threshold half of the time
  function automatic voxel_t rand_resolve();
    voxel_t v;
    int target;
    v.cmd = CMD_RESOLVE;
    v.last = 1'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    v.density = $urandom & 32'h7FFF_FFFF;
      2:       v.density = '0;
      default: v.density = $urandom | 32'h8000_0000;
    endcase
    case ($urandom_range(0, 3))
      0:       v.hits = '0;
      1:       v.hits = 24'd1;
      2:       v.hits = 24'($urandom_range(2, 4096));
      default: v.hits = 24'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        v.theo_cnt = 24'($urandom);
        v.before_cnt = 24'($urandom);
      end
      1, 2: begin
        target = int'(ray_thr) + int'($urandom_range(0, 4)) - 2;
        if (target < 0) target = 0;
        v.before_cnt = 24'($urandom_range(0, 32'hFF_FFFF - target));
        v.theo_cnt = v.before_cnt + 24'(target);
      end
      default: begin
        v.theo_cnt = 24'($urandom_range(0, 32'hFF_FFFE));
        v.before_cnt = 24'($urandom_range(v.theo_cnt + 1, 32'hFF_FFFF));
      end
    endcase
    return v;
  endfunction

  function automatic voxel_t rand_noise();
    return mk_voxel(1'($urandom), $urandom, 24'($urandom), 24'($urandom),
                    24'($urandom), 1'($urandom));
  endfunction

  // Hold the generator while the feed queue is full
  task automatic feed_voxel(input voxel_t v);
    while (voxel_feed.size() >= FEED_DEPTH) @(negedge clk);
    voxel_feed.push_back(v);
    cells_queued++;
  endtask

  task automatic run_slabs(input int n);
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(1, 16);
        for (int i = 0; i < k; i++) feed_voxel(rand_accum(i == k - 1));
        sent += k;
        k = $urandom_range(1, 16);
        for (int i = 0; i < k; i++) feed_voxel(rand_resolve());
        sent += k;
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) feed_voxel(rand_noise());
        sent += k;
      end
    end
  endtask

  // Wait for every word taken and every fill seen, then let a divide finish
  task automatic wait_idle();
    while (cells_taken != cells_queued || pending_fills.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_ray_threshold(input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_RAY_THRESHOLD;
    cfg_pwdata <= {{(32-THR_W){1'b0}}, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    ray_thr = val;
    n_thr++;
  endtask

  task automatic check_ray_threshold();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_RAY_THRESHOLD;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(32-THR_W){1'b0}}, ray_thr}) begin
      $display("%0t: ray_threshold read expected %h got %h", $time,
               {{(32-THR_W){1'b0}}, ray_thr}, cfg_prdata);
      cfg_errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Input driver: bursts of words with random gaps, fed from the voxel queue
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (voxel_feed.size() != 0) begin
        drv_voxel = voxel_feed.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {drv_voxel.before_cnt, drv_voxel.theo_cnt, drv_voxel.hits,
                     drv_voxel.density};
        in_tuser <= drv_voxel.cmd;
        in_tlast <= drv_voxel.last;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 31);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output stall pattern; two long hold-offs let the core back up
  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done < 2 && words_out >= (holds_done == 0 ? 24 : 220)) begin
      holds_done++;
      hold_left = HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_cycle[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= 1'($urandom);
        2'd2:    out_tready <= (rx_cycle[1:0] == 2'd0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: check result words first, then model the accepted input word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        words_out++;
        if (pending_fills.size() == 0) begin
          $display("%0t: unexpected word, expected none got %h/%0d", $time,
                   out_tdata, out_tuser);
          word_errors++;
        end else begin
          mon_fill = pending_fills.pop_front();
          case (mon_fill.kind)
            FILL_KEPT: n_kept++;
            FILL_MEAN: n_mean++;
            default:   n_zero++;
          endcase
          if (out_tdata !== mon_fill.density || out_tuser !== mon_fill.kind) begin
            $display("%0t: fill mismatch, expected %h/%0d got %h/%0d", $time,
                     mon_fill.density, mon_fill.kind, out_tdata, out_tuser);
            word_errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        mon_voxel.cmd = in_tuser;
        mon_voxel.density = in_tdata[31:0];
        mon_voxel.hits = in_tdata[55:32];
        mon_voxel.theo_cnt = in_tdata[79:56];
        mon_voxel.before_cnt = in_tdata[103:80];
        mon_voxel.last = in_tlast;
        track_slab(mon_voxel);
        cells_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d fills outstanding", $time, pending_fills.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_ray_threshold();

    // Directed: resolve before any latch, field extremes, empty slab,
    // truncated means, threshold edge, negative effective rays
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'hFFFF_0000, 24'd1, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h7FFF_FFFF, 24'd0, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h0000_0000, 24'hFF_FFFF, 24'hFF_FFFF,
                        24'hFF_FFFF, 1'b1));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h8000_0000, 24'd0, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h8000_0001, 24'd3, 24'd3, 24'd3, 1'b0));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h0000_0000, 24'd0, 24'd0, 24'd0, 1'b1));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'hFFFF_FFFF, 24'd1, 24'd5, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h7FFF_FFFF, 24'd0, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h7FFF_FFFF, 24'd0, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h0000_0001, 24'd0, 24'd0, 24'd0, 1'b1));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h8000_0000, 24'hFF_FFFF, 24'd10, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h8000_0000, 24'd1, 24'd11, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'hC000_0000, 24'd1, 24'd0, 24'hFF_FFFF, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'hC000_0000, 24'd1, 24'hFF_FFFF,
                        24'hFF_FFFF, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'hC000_0000, 24'd1, 24'hFF_FFFF, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'hFFFF_FFFF, 24'd0, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h0000_0003, 24'd0, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h0000_0004, 24'd0, 24'd0, 24'd0, 1'b1));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h8765_4321, 24'd2, 24'd20, 24'd10, 1'b1));
    feed_voxel(mk_voxel(CMD_ACCUMULATE, 32'h0001_0000, 24'd0, 24'd0, 24'd0, 1'b1));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h8000_0000, 24'd1, 24'd0, 24'd0, 1'b0));
    feed_voxel(mk_voxel(CMD_RESOLVE, 32'h0000_0001, 24'd1, 24'd0, 24'd0, 1'b0));
    wait_idle();

    // Random slabs over the threshold extremes, a mid value and a threshold of one
    write_ray_threshold('0);
    check_ray_threshold();
    run_slabs(150);
    wait_idle();

    write_ray_threshold({THR_W{1'b1}});
    check_ray_threshold();
    run_slabs(150);
    wait_idle();

    write_ray_threshold(THR_W'($urandom_range(1, 65534)));
    check_ray_threshold();
    run_slabs(150);
    wait_idle();

    write_ray_threshold(THR_W'(1));
    check_ray_threshold();
    run_slabs(150);
    wait_idle();

    $display("covered %0d accumulate words with %0d slab means and %0d resolve words",
             n_accum, n_latch, n_resolve);
    $display("fills kept %0d, mean %0d, zero %0d over %0d threshold settings",
             n_kept, n_mean, n_zero, n_thr);
    if (word_errors == 0 && cfg_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
